FILE: hw/rtl/ircfs_pkg.sv
// Shared types and constants of the IRC format code stripper.
// Holds the scan mode enum, the result descriptor struct and the code values.
// No dependencies.
package ircfs_pkg;

   // default group lengths
   localparam int HEX_COLOR_DIGITS_DEF     = 6;
   localparam int NUMERIC_COLOR_DIGITS_DEF = 2;

   // code units with a meaning of their own
   localparam logic [15:0] CODE_BOLD      = 16'h0002;
   localparam logic [15:0] CODE_COLOR     = 16'h0003;
   localparam logic [15:0] CODE_HEX_COLOR = 16'h0004;
   localparam logic [15:0] CODE_TAB       = 16'h0009;
   localparam logic [15:0] CODE_RESET     = 16'h000F;
   localparam logic [15:0] CODE_MONOSPACE = 16'h0011;
   localparam logic [15:0] CODE_REVERSE   = 16'h0016;
   localparam logic [15:0] CODE_ITALIC    = 16'h001D;
   localparam logic [15:0] CODE_STRIKE    = 16'h001E;
   localparam logic [15:0] CODE_UNDERLINE = 16'h001F;
   localparam logic [15:0] CODE_SPACE     = 16'h0020;
   localparam logic [15:0] CODE_COMMA     = 16'h002C;
   localparam logic [15:0] CODE_DEL       = 16'h007F;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_NORMAL    = 3'd0,
      MODE_NUM_FG    = 3'd1,
      MODE_NUM_COMMA = 3'd2,
      MODE_NUM_BG    = 3'd3,
      MODE_HEX_FG    = 3'd4,
      MODE_HEX_AFTER = 3'd5,
      MODE_HEX_BG    = 3'd6
   } mode_type;

   // shape of the result list of one beat: [comma] [held digits] [unit] or bare end
   typedef struct packed {
      logic comma;
      logic unit_keep;
      logic bare;
      logic end_mark;
   } desc_type;

endpackage

FILE: hw/rtl/ircfs_scan.sv
// Scanner of the IRC format code stripper: mode, digit counters, hold buffer,
// and the result list that each accepted beat produces.
// Depends on ircfs_pkg.
module ircfs_scan
   import ircfs_pkg::*;
#(
   parameter int HEX_COLOR_DIGITS     = HEX_COLOR_DIGITS_DEF,
   parameter int NUMERIC_COLOR_DIGITS = NUMERIC_COLOR_DIGITS_DEF,
   localparam int CNT_W = $clog2(HEX_COLOR_DIGITS + 1),
   localparam int IDX_W = (HEX_COLOR_DIGITS > 1) ? $clog2(HEX_COLOR_DIGITS) : 1,
   localparam int DC_W  = $clog2(NUMERIC_COLOR_DIGITS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [15:0]                          code_unit,
   input  logic                                 end_of_text,
   output desc_type                             desc,
   output logic [CNT_W-1:0]                     digit_n,
   output logic [HEX_COLOR_DIGITS-1:0][7:0]     digits
);

   mode_type         mode_ff, mode_in, mode_step;
   logic [DC_W-1:0]  dcount_ff, dcount_in;
   logic [CNT_W-1:0] hcount_ff, hcount_in, hcount_step, hinc;
   logic [7:0]       hold_ff [HEX_COLOR_DIGITS];
   logic [HEX_COLOR_DIGITS-1:0][7:0] buf_next;
   logic             hold_wr;

   logic is_dec, is_hex, is_comma, is_drop_ctl, do_plain, plain_keep;
   logic [CNT_W-1:0] fail_n, end_n;
   logic             rel_comma;

   // classify the incoming unit
   assign is_dec      = code_unit inside {[16'h0030:16'h0039]};
   assign is_hex      = is_dec || (code_unit inside {[16'h0061:16'h0066], [16'h0041:16'h0046]});
   assign is_comma    = (code_unit == CODE_COMMA);
   assign is_drop_ctl = ((code_unit < CODE_SPACE) && (code_unit != CODE_TAB))
                        || (code_unit == CODE_DEL);
   assign plain_keep  = !is_drop_ctl;

   // count of the hex group after holding this unit
   always_comb begin
      if (hcount_ff < CNT_W'(HEX_COLOR_DIGITS)) begin
         hinc = hcount_ff + CNT_W'(1);
      end else begin
         hinc = hcount_ff;
      end
   end

   // decide whether the unit falls back to plain text handling
   always_comb begin
      do_plain = 1'b0;
      case (mode_ff)
         MODE_NUM_FG: begin
            do_plain = !(is_dec && (dcount_ff < DC_W'(NUMERIC_COLOR_DIGITS))) && !is_comma;
         end
         MODE_NUM_COMMA: begin
            do_plain = !is_dec;
         end
         MODE_NUM_BG: begin
            do_plain = !(is_dec && (dcount_ff < DC_W'(NUMERIC_COLOR_DIGITS)));
         end
         MODE_HEX_FG, MODE_HEX_BG: begin
            do_plain = !is_hex;
         end
         MODE_HEX_AFTER: begin
            do_plain = !is_comma;
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      mode_step   = mode_ff;
      dcount_in   = dcount_ff;
      hcount_step = hcount_ff;
      hold_wr     = 1'b0;
      case (mode_ff)
         MODE_NUM_FG, MODE_NUM_BG: begin
            if (!do_plain) begin
               if (is_dec && (dcount_ff < DC_W'(NUMERIC_COLOR_DIGITS))) begin
                  dcount_in = dcount_ff + DC_W'(1);
               end else begin
                  mode_step = MODE_NUM_COMMA;
               end
            end
         end
         MODE_NUM_COMMA: begin
            if (!do_plain) begin
               mode_step = MODE_NUM_BG;
               dcount_in = DC_W'(1);
            end
         end
         MODE_HEX_FG, MODE_HEX_BG: begin
            if (!do_plain) begin
               hold_wr = (hcount_ff < CNT_W'(HEX_COLOR_DIGITS));
               if (hinc >= CNT_W'(HEX_COLOR_DIGITS)) begin
                  hcount_step = '0;
                  mode_step   = (mode_ff == MODE_HEX_FG) ? MODE_HEX_AFTER : MODE_NORMAL;
               end else begin
                  hcount_step = hinc;
               end
            end else begin
               hcount_step = '0;
            end
         end
         MODE_HEX_AFTER: begin
            if (!do_plain) begin
               mode_step   = MODE_HEX_BG;
               hcount_step = '0;
            end
         end
         default: begin
            mode_step = MODE_NORMAL;
         end
      endcase
      // plain text handling may open a new group
      if (do_plain) begin
         mode_step = MODE_NORMAL;
         if (code_unit == CODE_COLOR) begin
            mode_step = MODE_NUM_FG;
            dcount_in = '0;
         end else if (code_unit == CODE_HEX_COLOR) begin
            mode_step   = MODE_HEX_FG;
            hcount_step = '0;
         end
      end
      // the end of a text closes every group
      mode_in   = mode_step;
      hcount_in = hcount_step;
      if (end_of_text) begin
         mode_in   = MODE_NORMAL;
         dcount_in = '0;
         hcount_in = '0;
      end
   end

   // result list of this beat
   always_comb begin
      rel_comma = 1'b0;
      fail_n    = '0;
      end_n     = '0;
      case (mode_ff)
         MODE_NUM_COMMA: begin
            rel_comma = do_plain;
         end
         MODE_HEX_FG: begin
            if (do_plain) begin
               fail_n = hcount_ff;
            end
         end
         MODE_HEX_BG: begin
            if (do_plain) begin
               rel_comma = 1'b1;
               fail_n    = hcount_ff;
            end
         end
         default: begin
            rel_comma = 1'b0;
         end
      endcase
      if (end_of_text) begin
         case (mode_step)
            MODE_NUM_COMMA: begin
               rel_comma = 1'b1;
            end
            MODE_HEX_FG: begin
               end_n = hcount_step;
            end
            MODE_HEX_BG: begin
               rel_comma = 1'b1;
               end_n     = hcount_step;
            end
            default: begin
               end_n = '0;
            end
         endcase
      end
      digit_n        = fail_n + end_n;
      desc.comma     = rel_comma;
      desc.unit_keep = do_plain && plain_keep;
      desc.end_mark  = end_of_text;
      desc.bare      = end_of_text && !rel_comma && (digit_n == '0) && !(do_plain && plain_keep);
   end

   // hold buffer contents after this beat's write
   always_comb begin
      for (int i = 0; i < HEX_COLOR_DIGITS; i++) begin
         if (hold_wr && (hcount_ff[IDX_W-1:0] == IDX_W'(i))) begin
            buf_next[i] = code_unit[7:0];
         end else begin
            buf_next[i] = hold_ff[i];
         end
      end
   end

   assign digits = buf_next;

   // hold the control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         dcount_ff <= '0;
         hcount_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         dcount_ff <= dcount_in;
         hcount_ff <= hcount_in;
      end
   end

   // hold back hex digits
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HEX_COLOR_DIGITS; i++) begin
            hold_ff[i] <= buf_next[i];
         end
      end
   end

endmodule

FILE: hw/rtl/ircfs_drain.sv
// Result drain of the IRC format code stripper: takes the result list of one
// beat and sends it out one result per cycle unless rsp_stall holds it.
// Depends on ircfs_pkg.
module ircfs_drain
   import ircfs_pkg::*;
#(
   parameter int HEX_COLOR_DIGITS = HEX_COLOR_DIGITS_DEF,
   localparam int CNT_W = $clog2(HEX_COLOR_DIGITS + 1),
   localparam int REM_W = $clog2(HEX_COLOR_DIGITS + 3)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  desc_type                         desc,
   input  logic [15:0]                      unit,
   input  logic [CNT_W-1:0]                 digit_n,
   input  logic [HEX_COLOR_DIGITS-1:0][7:0] digits,
   output logic                             take_ok,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_out_unit,
   output logic                             rsp_has_char,
   output logic                             rsp_last
);

   logic             comma_ff, unit_keep_ff, bare_ff, end_ff;
   logic [15:0]      unit_ff;
   logic [CNT_W-1:0] left_ff;
   logic [7:0]       dig_ff [HEX_COLOR_DIGITS];

   logic             rsp_valid_ff, rsp_has_char_ff, rsp_last_ff;
   logic [15:0]      rsp_out_unit_ff;

   logic [REM_W-1:0] rem;
   logic             busy, out_load, pop, head_last;
   logic [15:0]      head_unit;
   logic             head_has;

   // results still waiting in the list
   assign rem = REM_W'(comma_ff) + REM_W'(left_ff) + REM_W'(unit_keep_ff) + REM_W'(bare_ff);
   assign busy      = (rem != '0);
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign pop       = busy && out_load;
   assign head_last = end_ff && (rem == REM_W'(1));
   assign take_ok   = !busy || (pop && (rem == REM_W'(1)));

   // pick the head of the list
   always_comb begin
      if (comma_ff) begin
         head_unit = CODE_COMMA;
         head_has  = 1'b1;
      end else if (left_ff != '0) begin
         head_unit = {8'h00, dig_ff[0]};
         head_has  = 1'b1;
      end else if (unit_keep_ff) begin
         head_unit = unit_ff;
         head_has  = 1'b1;
      end else begin
         head_unit = '0;
         head_has  = 1'b0;
      end
   end

   // load a new list or advance the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         comma_ff     <= 1'b0;
         unit_keep_ff <= 1'b0;
         bare_ff      <= 1'b0;
         left_ff      <= '0;
      end else if (load) begin
         comma_ff     <= desc.comma;
         unit_keep_ff <= desc.unit_keep;
         bare_ff      <= desc.bare;
         left_ff      <= digit_n;
      end else if (pop) begin
         if (comma_ff) begin
            comma_ff <= 1'b0;
         end else if (left_ff != '0) begin
            left_ff <= left_ff - CNT_W'(1);
         end else if (unit_keep_ff) begin
            unit_keep_ff <= 1'b0;
         end else begin
            bare_ff <= 1'b0;
         end
      end
   end

   // list payload; shift held digits out from entry 0
   always_ff @(posedge clock) begin
      if (load) begin
         end_ff  <= desc.end_mark;
         unit_ff <= unit;
         for (int i = 0; i < HEX_COLOR_DIGITS; i++) begin
            dig_ff[i] <= digits[i];
         end
      end else if (pop && !comma_ff && (left_ff != '0)) begin
         for (int i = 0; i < HEX_COLOR_DIGITS - 1; i++) begin
            dig_ff[i] <= dig_ff[i + 1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_out_unit_ff <= head_unit;
         rsp_has_char_ff <= head_has;
         rsp_last_ff     <= head_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_unit = rsp_out_unit_ff;
   assign rsp_has_char = rsp_has_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: hw/rtl/irc_format_code_stripper.sv
// IRC format code stripper: removes formatting codes from a stream of UTF-16
// code units. Depends on ircfs_pkg, ircfs_scan and ircfs_drain.
//
// Use:
//   req_ channel: one code unit per beat, req_end_of_text on the final unit.
//   rsp_ channel: cleaned text, one code unit per beat; rsp_has_char low marks
//   a bare end marker, rsp_last flags the final result of a text.
//   A beat yields zero to HEX_COLOR_DIGITS+1 results: dropped controls and
//   swallowed colour digits yield none, a failed colour group releases the
//   held units before the failing one, and the end of a text always yields
//   at least one result.
// Path: an accepted beat is loaded into the release list, and its results
//   move from there into the output register.
// Throughput: one beat per cycle while each beat yields at most one result
//   and rsp_stall is low; a beat with more results holds req_stall until its
//   last result leaves the release list through the single result register.
// Reset: synchronous, returns to plain text mode with nothing held and
//   the output register empty.
// Stall: while rsp_stall is high the output register holds its beat; further
//   beats are accepted until one with results waits in the release list.
module irc_format_code_stripper
   import ircfs_pkg::*;
#(
   parameter int HEX_COLOR_DIGITS     = HEX_COLOR_DIGITS_DEF,
   parameter int NUMERIC_COLOR_DIGITS = NUMERIC_COLOR_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_unit,
   output logic        rsp_has_char,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(HEX_COLOR_DIGITS + 1);

   desc_type                         desc;
   logic [CNT_W-1:0]                 digit_n;
   logic [HEX_COLOR_DIGITS-1:0][7:0] digits;
   logic                             take_ok, accept;

   // accept a beat once the release list is free or passes out its last result
   assign req_stall = !take_ok;
   assign accept    = req_valid && take_ok;

   ircfs_scan #(
      .HEX_COLOR_DIGITS    (HEX_COLOR_DIGITS),
      .NUMERIC_COLOR_DIGITS(NUMERIC_COLOR_DIGITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .code_unit  (req_code_unit),
      .end_of_text(req_end_of_text),
      .desc       (desc),
      .digit_n    (digit_n),
      .digits     (digits)
   );

   ircfs_drain #(
      .HEX_COLOR_DIGITS(HEX_COLOR_DIGITS)
   ) u_drain (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .desc        (desc),
      .unit        (req_code_unit),
      .digit_n     (digit_n),
      .digits      (digits),
      .take_ok     (take_ok),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_unit(rsp_out_unit),
      .rsp_has_char(rsp_has_char),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: hw/rtl/ircfs_checker.sv
// Port checker of the IRC format code stripper, bound to the top level.
// Depends on ircfs_pkg and irc_format_code_stripper.
module ircfs_checker
   import ircfs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_unit,
   input logic        rsp_has_char,
   input logic        rsp_last
);

   // a stalled result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_unit)
         && $stable(rsp_has_char) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // a result without a character is the bare end marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_last && (rsp_out_unit == 16'h0000))
      else $error("bare result is not a clean end marker");

   // no dropped control code ever reaches the output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_char |->
         ((rsp_out_unit >= CODE_SPACE) || (rsp_out_unit == CODE_TAB))
         && (rsp_out_unit != CODE_DEL))
      else $error("control code passed through");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind irc_format_code_stripper ircfs_checker u_ircfs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_unit(rsp_out_unit),
   .rsp_has_char(rsp_has_char),
   .rsp_last    (rsp_last)
);
